[rtl/rsas_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rsas_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned POS_W   = 10;

    // command codes carried in the cmd field
    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_SEARCH = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]                 cmd;
        logic signed [VALUE_W-1:0]  value;
    } t_in_item;

    typedef struct packed {
        logic               found;
        logic [POS_W-1:0]   position;
        logic               overflowed;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CMP
    } t_state;

    // sequencer to bisection unit
    typedef struct packed {
        logic init;    // load lo = 0, hi = count
        logic latch;   // capture mid of the current window
        logic step;    // narrow the window around the captured mid
        logic go_up;   // key above probe: lo = mid + 1, else hi = mid
    } t_bis_ctrl;

endpackage

`default_nettype wire

[rtl/rsas_bisect.sv]
`timescale 1ns / 1ps
`default_nettype none

module rsas_bisect
    import rsas_pkg::*;
#(
    parameter int unsigned IDX_W = 10,
    parameter int unsigned CNT_W = 11
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_bis_ctrl        i_ctrl,
    input  wire logic [CNT_W-1:0] i_count,
    input  wire logic [IDX_W-1:0] i_pivot,
    output logic      [IDX_W-1:0] o_slot,
    output logic      [IDX_W-1:0] o_mid,
    output logic                  o_more
);

    localparam int unsigned SUM_W = CNT_W + 1;

    logic [CNT_W-1:0] r_lo, n_lo;
    logic [CNT_W-1:0] r_hi, n_hi;
    logic [IDX_W-1:0] r_mid;

    logic [CNT_W-1:0] mid_full;
    logic [SUM_W-1:0] slot_sum;
    logic [SUM_W-1:0] slot_wrap;
    logic [CNT_W-1:0] mid_inc;

    // mid = lo + (hi - lo - 1) / 2; window is non-empty whenever this is used
    assign mid_full = r_lo + ((r_hi - r_lo - CNT_W'(1)) >> 1);

    always_comb begin
        slot_sum = SUM_W'(mid_full[IDX_W-1:0]) + SUM_W'(i_pivot);
        if (slot_sum >= SUM_W'(i_count)) begin
            slot_wrap = slot_sum - SUM_W'(i_count);
        end else begin
            slot_wrap = slot_sum;
        end
        if (slot_wrap >= SUM_W'(1 << IDX_W)) begin
            o_slot = '0;
        end else begin
            o_slot = slot_wrap[IDX_W-1:0];
        end
    end

    assign mid_inc = CNT_W'(r_mid) + CNT_W'(1);

    always_comb begin
        if (i_ctrl.go_up) begin
            n_lo = mid_inc;
            n_hi = r_hi;
        end else begin
            n_lo = r_lo;
            n_hi = CNT_W'(r_mid);
        end
    end

    assign o_more = n_lo < n_hi;
    assign o_mid  = r_mid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo <= '0;
            r_hi <= '0;
        end else if (i_ctrl.init) begin
            r_lo <= '0;
            r_hi <= i_count;
        end else if (i_ctrl.step) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.latch) begin
            r_mid <= mid_full[IDX_W-1:0];
        end
    end

endmodule

`default_nettype wire

[rtl/rotated_sorted_array_search_core.sv]
// Append and clear: busy stays low, no result.
// Search: each probe is an address plus registered read (ST_PROBE), then
// a compare (ST_CMP); the result strobes the cycle after the last compare.
// Search of an empty store answers on the next cycle.
// Reset clears count, pivot and flags; store contents stay unknown (no sweep).
// The receiver cannot stall: o_done is high for exactly one cycle per result.
`timescale 1ns / 1ps
`default_nettype none

module rotated_sorted_array_search_core
    import rsas_pkg::*;
#(
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      start,
    input  wire t_in_item  i_item,
    output logic           busy,
    output logic           o_done,
    output t_out_item      o_result
);

    localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic signed [VALUE_W-1:0] r_mem [DEPTH];
    logic signed [VALUE_W-1:0] r_rdata;

    logic [CNT_W-1:0]          r_count;
    logic [IDX_W-1:0]          r_pivot;
    logic                      r_pivot_seen;
    logic signed [VALUE_W-1:0] r_prev;
    logic                      r_ovf;
    logic signed [VALUE_W-1:0] r_key;

    t_state    r_state, n_state;
    t_bis_ctrl ctrl;
    logic      r_done, n_done;
    t_out_item r_result, n_result;

    logic [IDX_W-1:0] slot;
    logic [IDX_W-1:0] mid;
    logic             more;
    logic             accept;
    logic             full;
    logic             hit;
    logic [IDX_W+POS_W-1:0] mid_ext;

    assign accept = start && (r_state == ST_IDLE);
    assign full   = (r_count == CNT_W'(DEPTH));
    assign hit    = (r_key == r_rdata);
    assign mid_ext = {{POS_W{1'b0}}, mid};

    rsas_bisect #(
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_bisect (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl),
        .i_count (r_count),
        .i_pivot (r_pivot),
        .o_slot  (slot),
        .o_mid   (mid),
        .o_more  (more)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (i_item.cmd == CMD_SEARCH) && (r_count != '0)) begin
                    n_state = ST_PROBE;
                end
            end
            ST_PROBE: begin
                n_state = ST_CMP;
            end
            ST_CMP: begin
                if (!hit && more) begin
                    n_state = ST_PROBE;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        ctrl     = '0;
        n_done   = 1'b0;
        n_result = '{found: 1'b0, position: '0, overflowed: r_ovf};
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (i_item.cmd == CMD_SEARCH)) begin
                    ctrl.init = 1'b1;
                    n_done    = (r_count == '0);
                end
            end
            ST_PROBE: begin
                ctrl.latch = 1'b1;
            end
            ST_CMP: begin
                ctrl.go_up = (r_key > r_rdata);
                ctrl.step  = !hit;
                if (hit) begin
                    n_done            = 1'b1;
                    n_result.found    = 1'b1;
                    n_result.position = mid_ext[POS_W-1:0];
                end else if (!more) begin
                    n_done = 1'b1;
                end
            end
            default: begin
                ctrl = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        if (accept) begin
            r_key <= i_item.value;
        end
    end

    // load, clear and flag tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_pivot      <= '0;
            r_pivot_seen <= 1'b0;
            r_prev       <= '0;
            r_ovf        <= 1'b0;
        end else if (accept) begin
            priority if (i_item.cmd == CMD_CLEAR) begin
                r_count      <= '0;
                r_pivot      <= '0;
                r_pivot_seen <= 1'b0;
                r_prev       <= '0;
                r_ovf        <= 1'b0;
            end else if (i_item.cmd == CMD_APPEND) begin
                if (full) begin
                    r_ovf <= 1'b1;
                end else begin
                    // first descent marks the pivot
                    if ((r_count != '0) && !r_pivot_seen && (i_item.value < r_prev)) begin
                        r_pivot      <= r_count[IDX_W-1:0];
                        r_pivot_seen <= 1'b1;
                    end
                    r_count <= r_count + CNT_W'(1);
                    r_prev  <= i_item.value;
                end
            end else begin
                r_count <= r_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (i_item.cmd == CMD_APPEND) && !full) begin
            r_mem[r_count[IDX_W-1:0]] <= i_item.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_PROBE) begin
            r_rdata <= r_mem[slot];
        end
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while search still running");

    a_done_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(r_state) == ST_CMP) || ($past(accept) && ($past(i_item.cmd) == CMD_SEARCH)))
        else $error("result strobe without a search ending");

    a_miss_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.found) |-> (o_result.position == '0))
        else $error("miss reported with non-zero position");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("element count beyond capacity");

    a_pivot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pivot_seen |-> (CNT_W'(r_pivot) < r_count))
        else $error("pivot outside loaded range");

endmodule

`default_nettype wire
